FILE: sv/rrfp_pkg.sv
// Package: constants, codes and types for the radar report frame parser.
package rrfp_pkg;

    localparam int MAX_FRAME      = 64;
    localparam int FRAME_OVERHEAD = 10;
    localparam int LEN_LIMIT      = MAX_FRAME - FRAME_OVERHEAD;
    localparam int POS_W          = $clog2(MAX_FRAME + 1);
    localparam int CAP_FIRST      = 6;
    localparam int CAP_COUNT      = 11;
    localparam int HEADER_BYTES   = 4;
    localparam int LEN_W          = 16;
    localparam int CMP_W          = LEN_W + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_HEADER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_TAIL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_TAIL    = 2'd3;

    localparam logic [31:0] DATA_HEADER_RST = 32'hF1F2F3F4;
    localparam logic [31:0] CMD_HEADER_RST  = 32'hFDFCFBFA;
    localparam logic [31:0] DATA_TAIL_RST   = 32'hF5F6F7F8;
    localparam logic [31:0] CMD_TAIL_RST    = 32'h04030201;

    localparam logic [1:0] PHASE_HUNT = 2'd0;
    localparam logic [1:0] PHASE_LEN  = 2'd1;
    localparam logic [1:0] PHASE_BODY = 2'd2;

    localparam logic [2:0] ST_TARGET   = 3'd0;
    localparam logic [2:0] ST_ENG      = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE = 3'd2;
    localparam logic [2:0] ST_BAD_HEAD = 3'd3;
    localparam logic [2:0] ST_BAD_TAIL = 3'd4;
    localparam logic [2:0] ST_BAD_LEN  = 3'd5;

    localparam logic [7:0] TYPE_TARGET = 8'h02;
    localparam logic [7:0] TYPE_ENG    = 8'h01;
    localparam logic [7:0] HEAD_MARK   = 8'hAA;

    typedef logic [7:0] byte_t;
    typedef byte_t [CAP_COUNT-1:0] cap_t;

endpackage

FILE: sv/radar_report_frame_parser_core.sv
// Top level: byte-serial radar report frame parser with registered result.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  in       | in_valid / in_ready   | rx_byte
//  out      | out_valid / out_ready | frame_status, target fields, frame counters
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte per cycle while in_ready is high: each accepted byte updates the
// parser state in the cycle it arrives; a frame result lands in the output
// register at the next edge, with out_valid registered alongside it.
// in_ready drops only while a result is held and out_ready is low.
// rst_n clears parser state, counters, captured bytes and restores the
// header and tail registers. cfg writes are always taken.
module radar_report_frame_parser_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    frame_status,
    output logic [7:0]                    tgt_state,
    output logic [15:0]                   move_dist,
    output logic [7:0]                    move_energy,
    output logic [15:0]                   still_dist,
    output logic [7:0]                    still_energy,
    output logic [15:0]                   detect_dist,
    output logic [31:0]                   good_frame_count,
    output logic [31:0]                   bad_frame_count,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rrfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import rrfp_pkg::*;

    logic [31:0]      data_header_reg;
    logic [31:0]      cmd_header_reg;
    logic [31:0]      data_tail_reg;
    logic [31:0]      cmd_tail_reg;

    logic [1:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      header_reg, header_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [31:0]      tail_reg, tail_next;
    cap_t             cap_reg, cap_next;
    logic [31:0]      ok_reg, ok_next;
    logic [31:0]      err_reg, err_next;

    logic             out_valid_reg;
    logic [2:0]       status_reg;
    logic [7:0]       state_reg;
    logic [15:0]      mdist_reg;
    logic [7:0]       menergy_reg;
    logic [15:0]      sdist_reg;
    logic [7:0]       senergy_reg;
    logic [15:0]      ddist_reg;
    logic [31:0]      good_reg;
    logic [31:0]      bad_reg;

    logic             accept;
    logic             emit;
    logic [2:0]       emit_status;
    logic [POS_W-1:0] pos_inc;
    logic [31:0]      hunt_window;
    logic [LEN_W-1:0] len_full;
    logic             frame_done;
    logic             tail_good;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign pos_inc   = pos_reg + POS_W'(1);
    assign hunt_window = {rx_byte, header_reg[31:8]};
    assign len_full  = {rx_byte, len_reg[7:0]};
    assign frame_done = CMP_W'(pos_inc) >= (CMP_W'(len_reg) + CMP_W'(FRAME_OVERHEAD));

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        header_next = header_reg;
        len_next    = len_reg;
        tail_next   = tail_reg;
        cap_next    = cap_reg;
        ok_next     = ok_reg;
        err_next    = err_reg;
        emit        = 1'b0;
        emit_status = ST_TARGET;
        tail_good   = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PHASE_HUNT:
                begin
                    header_next = hunt_window;
                    if (pos_reg < POS_W'(HEADER_BYTES))
                    begin
                        pos_next = pos_inc;
                    end
                    if ((pos_next == POS_W'(HEADER_BYTES)) &&
                        (hunt_window == data_header_reg || hunt_window == cmd_header_reg))
                    begin
                        phase_next = PHASE_LEN;
                    end
                end
                PHASE_LEN:
                begin
                    if (pos_reg == POS_W'(HEADER_BYTES))
                    begin
                        len_next = LEN_W'(rx_byte);
                        pos_next = pos_inc;
                    end
                    else
                    begin
                        len_next = len_full;
                        if (32'(len_full) > 32'(LEN_LIMIT))
                        begin
                            err_next    = err_reg + 32'd1;
                            emit        = 1'b1;
                            emit_status = ST_BAD_LEN;
                            phase_next  = PHASE_HUNT;
                            pos_next    = '0;
                            header_next = '0;
                        end
                        else
                        begin
                            pos_next   = POS_W'(CAP_FIRST);
                            tail_next  = '0;
                            phase_next = PHASE_BODY;
                        end
                    end
                end
                PHASE_BODY:
                begin
                    for (int i = 0; i < CAP_COUNT; i++)
                    begin
                        if (pos_reg == POS_W'(CAP_FIRST + i))
                        begin
                            cap_next[i] = rx_byte;
                        end
                    end
                    tail_next = {rx_byte, tail_reg[31:8]};
                    pos_next  = pos_inc;
                    if (frame_done)
                    begin
                        tail_good = (header_reg == data_header_reg && tail_next == data_tail_reg) ||
                                    (header_reg == cmd_header_reg && tail_next == cmd_tail_reg);
                        phase_next  = PHASE_HUNT;
                        pos_next    = '0;
                        header_next = '0;
                        emit        = 1'b1;
                        if (!tail_good)
                        begin
                            err_next    = err_reg + 32'd1;
                            emit_status = ST_BAD_TAIL;
                        end
                        else
                        begin
                            ok_next = ok_reg + 32'd1;
                            priority if (cap_next[0] != TYPE_TARGET && cap_next[0] != TYPE_ENG)
                            begin
                                emit_status = ST_BAD_TYPE;
                            end
                            else if (cap_next[1] != HEAD_MARK)
                            begin
                                emit_status = ST_BAD_HEAD;
                            end
                            else if (cap_next[0] == TYPE_TARGET)
                            begin
                                emit_status = ST_TARGET;
                            end
                            else
                            begin
                                emit_status = ST_ENG;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next  = PHASE_HUNT;
                    pos_next    = '0;
                    header_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_header_reg <= DATA_HEADER_RST;
            cmd_header_reg  <= CMD_HEADER_RST;
            data_tail_reg   <= DATA_TAIL_RST;
            cmd_tail_reg    <= CMD_TAIL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DATA_HEADER: data_header_reg <= cfg_data;
                REG_CMD_HEADER:  cmd_header_reg  <= cfg_data;
                REG_DATA_TAIL:   data_tail_reg   <= cfg_data;
                REG_CMD_TAIL:    cmd_tail_reg    <= cfg_data;
                default:         data_header_reg <= data_header_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PHASE_HUNT;
            pos_reg    <= '0;
            header_reg <= '0;
            len_reg    <= '0;
            tail_reg   <= '0;
            cap_reg    <= '0;
            ok_reg     <= '0;
            err_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            header_reg <= header_next;
            len_reg    <= len_next;
            tail_reg   <= tail_next;
            cap_reg    <= cap_next;
            ok_reg     <= ok_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // decoded fields are zero on any error status
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= emit_status;
            good_reg   <= ok_next;
            bad_reg    <= err_next;
            if (emit_status == ST_TARGET || emit_status == ST_ENG)
            begin
                state_reg   <= cap_next[2];
                mdist_reg   <= {cap_next[4], cap_next[3]};
                menergy_reg <= cap_next[5];
                sdist_reg   <= {cap_next[7], cap_next[6]};
                senergy_reg <= cap_next[8];
                ddist_reg   <= {cap_next[10], cap_next[9]};
            end
            else
            begin
                state_reg   <= '0;
                mdist_reg   <= '0;
                menergy_reg <= '0;
                sdist_reg   <= '0;
                senergy_reg <= '0;
                ddist_reg   <= '0;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign frame_status       = status_reg;
    assign tgt_state          = state_reg;
    assign move_dist          = mdist_reg;
    assign move_energy        = menergy_reg;
    assign still_dist         = sdist_reg;
    assign still_energy       = senergy_reg;
    assign detect_dist        = ddist_reg;
    assign good_frame_count   = good_reg;
    assign bad_frame_count    = bad_reg;

endmodule
